/* design/rwch_pkg.sv */
// ----------------------------------------------------------------------------
// rwch_pkg
// Types and constants shared by the risk warning confirm-and-hold block.
// ----------------------------------------------------------------------------
package rwch_pkg;

    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 8;
    localparam int FRAME_W     = 21;

    localparam logic [1:0] LEVEL_SAFE    = 2'd0;
    localparam logic [1:0] LEVEL_CAUTION = 2'd1;
    localparam logic [1:0] LEVEL_DANGER  = 2'd2;

    localparam logic [1:0] CFG_HOLD_FRAMES     = 2'd0;
    localparam logic [1:0] CFG_CAUTION_CONFIRM = 2'd1;
    localparam logic [1:0] CFG_DANGER_CONFIRM  = 2'd2;

    localparam logic [7:0] HOLD_FRAMES_RST     = 8'd8;
    localparam logic [7:0] CAUTION_CONFIRM_RST = 8'd8;
    localparam logic [7:0] DANGER_CONFIRM_RST  = 8'd3;

    localparam logic [7:0]         COUNT_MAX = 8'hFF;
    localparam logic signed [15:0] LEAD_NONE = -16'sd1;

    // Packed so that analysis_enabled sits in bit 0 of the stream word.
    typedef struct packed {
        logic [1:0]         raw_level;
        logic signed [15:0] lead_id;
        logic               risk_found;
        logic               scene_changed;
        logic               analysis_enabled;
    } t_frame;

    typedef struct packed {
        logic [7:0] hold_frames;
        logic [7:0] caution_confirm;
        logic [7:0] danger_confirm;
    } t_cfg;

endpackage

/* design/risk_warning_confirm_hold.sv */
// ----------------------------------------------------------------------------
// risk_warning_confirm_hold
// Per-frame risk banner with consecutive-frame confirmation and hold timers.
// ----------------------------------------------------------------------------
// The block takes one frame transaction per clock cycle, unless the output
// is stalled, and returns one banner level for each from the result register.
// The state update for a frame is done combinationally between the input
// register and the result register, so the rate is one frame per cycle
// while the output is not stalled. Configuration writes are taken at any
// time and should be made only while no frame is in flight.
module risk_warning_confirm_hold (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // analysis_enabled[0], scene_changed[1], risk_found[2], lead_id[18:3],
    // raw_level[20:19], zero fill[23:21]
    input  logic [rwch_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // banner_level[1:0], zero fill[7:2]
    output logic [rwch_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [1:0]                         i_cfg_index,
    input  logic [7:0]                         i_cfg_data
);
    import rwch_pkg::*;

    t_cfg       cfg;
    t_frame     in_frame, reg_frame;
    logic       reg_valid, advance;
    logic [1:0] core_banner, out_banner;

    assign in_frame = t_frame'(s_axis_tdata[FRAME_W-1:0]);

    rwch_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    rwch_in_reg u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_frame   (in_frame),
        .o_valid   (reg_valid),
        .i_advance (advance),
        .o_frame   (reg_frame)
    );

    rwch_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (reg_valid && advance),
        .i_frame  (reg_frame),
        .i_cfg    (cfg),
        .o_banner (core_banner)
    );

    rwch_out_reg u_out (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (reg_valid),
        .i_banner  (core_banner),
        .o_advance (advance),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_banner  (out_banner)
    );

    assign m_axis_tdata = {{(OUT_TDATA_W-2){1'b0}}, out_banner};

endmodule

/* design/rwch_cfg_regs.sv */
// ----------------------------------------------------------------------------
// rwch_cfg_regs
// Configuration register file for the confirm thresholds and hold length.
// ----------------------------------------------------------------------------
module rwch_cfg_regs (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [1:0]    i_cfg_index,
    input  logic [7:0]    i_cfg_data,
    output rwch_pkg::t_cfg o_cfg
);
    import rwch_pkg::*;

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.hold_frames     <= HOLD_FRAMES_RST;
            r_cfg.caution_confirm <= CAUTION_CONFIRM_RST;
            r_cfg.danger_confirm  <= DANGER_CONFIRM_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_HOLD_FRAMES:     r_cfg.hold_frames     <= i_cfg_data;
                CFG_CAUTION_CONFIRM: r_cfg.caution_confirm <= i_cfg_data;
                CFG_DANGER_CONFIRM:  r_cfg.danger_confirm  <= i_cfg_data;
                default: ;
            endcase
        end
    end

endmodule

/* design/rwch_in_reg.sv */
// ----------------------------------------------------------------------------
// rwch_in_reg
// Input register stage that captures one frame transaction per cycle unless stalled.
// ----------------------------------------------------------------------------
module rwch_in_reg (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  rwch_pkg::t_frame      i_frame,
    output logic                  o_valid,
    input  logic                  i_advance,
    output rwch_pkg::t_frame      o_frame
);
    import rwch_pkg::*;

    logic   r_valid;
    t_frame r_frame;

    assign o_ready = !r_valid || i_advance;
    assign o_valid = r_valid;
    assign o_frame = r_frame;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_frame <= i_frame;
        end
    end

endmodule

/* design/rwch_core.sv */
// ----------------------------------------------------------------------------
// rwch_core
// Confirmation counters, hold timers and tracked lead, updated once per frame.
// ----------------------------------------------------------------------------
module rwch_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  rwch_pkg::t_frame i_frame,
    input  rwch_pkg::t_cfg   i_cfg,
    output logic [1:0]       o_banner
);
    import rwch_pkg::*;

    logic [7:0]         r_caution_count, n_caution_count;
    logic [7:0]         r_danger_count,  n_danger_count;
    logic [7:0]         r_caution_hold,  n_caution_hold;
    logic [7:0]         r_danger_hold,   n_danger_hold;
    logic signed [15:0] r_tracked_lead,  n_tracked_lead;

    logic [7:0] base_caution, base_danger, inc_caution, inc_danger;
    logic [7:0] dec_caution_hold, dec_danger_hold;

    always_comb begin
        dec_caution_hold = (r_caution_hold != 8'd0) ? r_caution_hold - 8'd1 : 8'd0;
        dec_danger_hold  = (r_danger_hold  != 8'd0) ? r_danger_hold  - 8'd1 : 8'd0;

        base_caution = (r_tracked_lead != i_frame.lead_id) ? 8'd0 : r_caution_count;
        base_danger  = (r_tracked_lead != i_frame.lead_id) ? 8'd0 : r_danger_count;
        inc_caution  = (base_caution == COUNT_MAX) ? COUNT_MAX : base_caution + 8'd1;
        inc_danger   = (base_danger  == COUNT_MAX) ? COUNT_MAX : base_danger  + 8'd1;

        n_caution_count = 8'd0;
        n_danger_count  = 8'd0;
        n_caution_hold  = dec_caution_hold;
        n_danger_hold   = dec_danger_hold;
        n_tracked_lead  = LEAD_NONE;

        if (!i_frame.analysis_enabled || i_frame.scene_changed) begin
            n_caution_hold = 8'd0;
            n_danger_hold  = 8'd0;
        end else if (i_frame.risk_found && !i_frame.lead_id[15]) begin
            n_tracked_lead = i_frame.lead_id;
            case (i_frame.raw_level)
                LEVEL_DANGER: begin
                    n_danger_count = inc_danger;
                    n_caution_hold = r_caution_hold;
                    n_danger_hold  = r_danger_hold;
                    if (inc_danger >= i_cfg.danger_confirm) begin
                        n_danger_hold  = i_cfg.hold_frames;
                        n_caution_hold = 8'd0;
                    end
                end
                LEVEL_CAUTION: begin
                    n_caution_count = inc_caution;
                    n_caution_hold  = r_caution_hold;
                    if (inc_caution >= i_cfg.caution_confirm) begin
                        n_caution_hold = i_cfg.hold_frames;
                    end
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        if (n_danger_hold != 8'd0) begin
            o_banner = LEVEL_DANGER;
        end else if (n_caution_hold != 8'd0) begin
            o_banner = LEVEL_CAUTION;
        end else begin
            o_banner = LEVEL_SAFE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_caution_count <= 8'd0;
            r_danger_count  <= 8'd0;
            r_caution_hold  <= 8'd0;
            r_danger_hold   <= 8'd0;
            r_tracked_lead  <= LEAD_NONE;
        end else if (i_fire) begin
            r_caution_count <= n_caution_count;
            r_danger_count  <= n_danger_count;
            r_caution_hold  <= n_caution_hold;
            r_danger_hold   <= n_danger_hold;
            r_tracked_lead  <= n_tracked_lead;
        end
    end

endmodule

/* design/rwch_out_reg.sv */
// ----------------------------------------------------------------------------
// rwch_out_reg
// Result register that holds the banner level until the sink takes it.
// ----------------------------------------------------------------------------
module rwch_out_reg (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [1:0] i_banner,
    output logic       o_advance,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [1:0] o_banner
);
    logic       r_valid;
    logic [1:0] r_banner;

    assign o_advance = !r_valid || i_ready;
    assign o_valid   = r_valid;
    assign o_banner  = r_banner;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_advance) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_advance && i_valid) begin
            r_banner <= i_banner;
        end
    end

endmodule

/* design/rwch_checker.sv */
// ----------------------------------------------------------------------------
// rwch_checker
// Port-level checks for the risk warning confirm-and-hold block.
// ----------------------------------------------------------------------------
module rwch_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       s_axis_tready,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata
);

    // The input side stalls only when a result is waiting at the output.
    a_stall_needs_backlog: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with no pending result");

    // A stalled result keeps its value.
    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // Banner codes are safe, caution or danger with zero fill above.
    a_banner_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[7:2] == 6'd0) && (m_axis_tdata[1:0] != 2'd3))
        else $error("illegal banner code");

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

endmodule

bind risk_warning_confirm_hold rwch_checker u_rwch_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
